// ===== design/mi_pkg.sv =====
package mi_pkg;
  localparam int unsigned WidthDefault = 32;

  typedef struct packed {
    logic load;
    logic div_start;
    logic step;
    logic fin_start;
  } mi_cmd_t;

  typedef struct packed {
    logic div_done;
    logic r1_zero;
    logic m_zero;
    logic fin_done;
  } mi_sts_t;
endpackage

// ===== design/mi_divider.sv =====
module mi_divider #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);
  localparam int unsigned CntW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] dsr;
  logic [CntW-1:0]  cnt;
  logic             busy;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   shifted;

  assign shifted = {rem, quo[WIDTH-1]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(WIDTH);
        rem  <= '0;
        quo  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        if (!trial[WIDTH]) begin
          rem <= trial[WIDTH-1:0];
          quo <= {quo[WIDTH-2:0], 1'b1};
        end else begin
          rem <= shifted[WIDTH-1:0];
          quo <= {quo[WIDTH-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
endmodule

// ===== design/mi_datapath.sv =====
module mi_datapath #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  mi_pkg::mi_cmd_t     cmd,
  output mi_pkg::mi_sts_t     sts,
  input  logic [WIDTH-1:0]    value,
  input  logic [WIDTH-1:0]    modulus,
  output logic [WIDTH-1:0]    inverse,
  output logic                exists,
  output logic [WIDTH-1:0]    common_divisor
);
  import mi_pkg::*;

  logic [WIDTH-1:0] m;
  logic [WIDTH-1:0] r0;
  logic [WIDTH-1:0] r1;
  logic [WIDTH-1:0] u0;
  logic [WIDTH-1:0] u1;
  logic             n0;
  logic             first;
  logic [WIDTH-1:0] dvd;
  logic [WIDTH-1:0] dvs;
  logic             div_done;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] prod;
  logic [WIDTH-1:0] u2;
  logic             fin_busy;
  logic             fin_done;
  logic [WIDTH-1:0] mag;

  assign dvd = first ? value : r0;
  assign dvs = first ? modulus : r1;
  assign prod = quo * u1;
  assign u2 = u0 + prod;

  mi_divider #(.WIDTH(WIDTH)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(dvd), .divisor(dvs),
    .done(div_done), .quotient(quo), .remainder(rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      first    <= 1'b0;
      fin_busy <= 1'b0;
      fin_done <= 1'b0;
    end else begin
      fin_done <= 1'b0;
      if (cmd.load) begin
        m     <= modulus;
        r0    <= modulus;
        r1    <= value;
        u0    <= '0;
        u1    <= {{(WIDTH-1){1'b0}}, 1'b1};
        n0    <= 1'b1;
        first <= 1'b1;
      end else if (cmd.step) begin
        if (first) begin
          r1    <= rem;
          first <= 1'b0;
        end else begin
          r0 <= r1;
          r1 <= rem;
          u0 <= u1;
          u1 <= u2;
          n0 <= ~n0;
        end
      end
      if (cmd.fin_start) begin
        fin_busy <= 1'b1;
      end else if (fin_busy) begin
        fin_busy <= 1'b0;
        fin_done <= 1'b1;
        common_divisor <= (m == '0) ? value : r0;
        exists <= (m != '0) && (r0 == {{(WIDTH-1){1'b0}}, 1'b1});
        if ((m == '0) || (r0 != {{(WIDTH-1){1'b0}}, 1'b1}) || (mag == '0)) begin
          inverse <= '0;
        end else if (n0) begin
          inverse <= m - mag;
        end else begin
          inverse <= mag;
        end
      end
    end
  end

  assign mag = (u0 >= m) ? '0 : u0;

  assign sts.div_done = div_done;
  assign sts.r1_zero  = (r1 == '0);
  assign sts.m_zero   = (m == '0);
  assign sts.fin_done = fin_done;
endmodule

// ===== design/mi_control.sv =====
module mi_control (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  logic            out_free,
  input  mi_pkg::mi_sts_t sts,
  output mi_pkg::mi_cmd_t cmd,
  output logic            idle,
  output logic            result_ready
);
  import mi_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_DIV, S_FIN, S_WAIT} state_t;
  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cmd <= '0;
      result_ready <= 1'b0;
    end else begin
      cmd <= '0;
      result_ready <= 1'b0;
      unique case (state)
        S_IDLE: if (in_fire) begin
          cmd.load <= 1'b1;
          state <= S_CHECK;
        end
        S_CHECK: if (!cmd.step && !cmd.load) begin
          if (sts.m_zero || sts.r1_zero) begin
            cmd.fin_start <= 1'b1;
            state <= S_FIN;
          end else begin
            cmd.div_start <= 1'b1;
            state <= S_DIV;
          end
        end
        S_DIV: if (sts.div_done) begin
          cmd.step <= 1'b1;
          state <= S_CHECK;
        end
        S_FIN: if (sts.fin_done) begin
          state <= S_WAIT;
        end
        S_WAIT: if (out_free) begin
          result_ready <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle = (state == S_IDLE);
endmodule

// ===== design/modular_inverse.sv =====
// Modular inverse by the extended Euclidean algorithm: each item takes value and modulus
// and returns the gcd, an exists flag and the inverse in 0..modulus-1. One item is in
// work at a time, and its run time is set by the bit-serial divider (one quotient bit per
// cycle) shared by every Euclid step. The result sits in an output register, and the
// next item is accepted once the result has been moved into it.
module modular_inverse #(
  parameter int unsigned WIDTH = mi_pkg::WidthDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [2*WIDTH-1:0]    s_tdata,  // value, modulus
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [2*WIDTH+7:0]    m_tdata   // inverse, exists, common_divisor, zero fill
);
  import mi_pkg::*;

  mi_cmd_t cmd;
  mi_sts_t sts;
  logic idle;
  logic result_ready;
  logic [WIDTH-1:0] value;
  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] inverse;
  logic exists;
  logic [WIDTH-1:0] common_divisor;
  logic in_fire;

  assign s_tready = idle;
  assign in_fire  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      value   <= s_tdata[WIDTH-1:0];
      modulus <= s_tdata[2*WIDTH-1:WIDTH];
    end
  end

  mi_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .value(value), .modulus(modulus),
    .inverse(inverse), .exists(exists), .common_divisor(common_divisor)
  );

  mi_control u_ctl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(!m_tvalid || m_tready),
    .sts(sts), .cmd(cmd), .idle(idle), .result_ready(result_ready)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (result_ready) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {7'b0, common_divisor, exists, inverse};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    !idle |-> !s_tready) else $error("item taken while busy");
  a_exists_gcd: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[WIDTH]) |-> (m_tdata[2*WIDTH:WIDTH+1] == WIDTH'(1)))
    else $error("exists without unit gcd");
  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[WIDTH]) |-> (m_tdata[WIDTH-1:0] == '0))
    else $error("inverse without existence");
endmodule

// ===== test/modinv_checker.sv =====
module modinv_checker #(
  parameter int unsigned WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [2*WIDTH-1:0] s_tdata,
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [2*WIDTH+7:0] m_tdata,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WIDTH-1:0] inverse;
    logic             exists;
    logic [WIDTH-1:0] divisor;
  } inv_result_t;

  inv_result_t expected_q[$];

  function automatic inv_result_t solve_inverse(logic [WIDTH-1:0] a, logic [WIDTH-1:0] m);
    inv_result_t res;
    logic [WIDTH:0] r0, r1, r2, q;
    logic [127:0] u0, u1, u2;
    logic neg0, neg1;
    res = '0;
    if (m == 0) begin
      res.divisor = a;
    end else begin
      r0 = m;
      r1 = a % m;
      u0 = 0;
      u1 = 1;
      neg0 = 1'b0;
      neg1 = 1'b0;
      while (r1 != 0) begin
        q = r0 / r1;
        r2 = r0 - q * r1;
        u2 = u0 + q * u1;
        r0 = r1;
        r1 = r2;
        u0 = u1;
        u1 = u2;
        neg0 = neg1;
        neg1 = !neg1;
      end
      res.divisor = r0[WIDTH-1:0];
      if (r0 == 1) begin
        res.exists = 1'b1;
        if (u0 == 0) res.inverse = '0;
        else if (neg0) res.inverse = m - (u0 % m);
        else res.inverse = u0 % m;
        if (res.inverse >= m) res.inverse = '0;
      end
    end
    return res;
  endfunction

  inv_result_t got, want;
  int bad;

  always @(posedge clk) begin
    if (rst) begin
      expected_q.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      bad = 0;
      if (m_tvalid && m_tready) begin
        got.inverse = m_tdata[WIDTH-1:0];
        got.exists  = m_tdata[WIDTH];
        got.divisor = m_tdata[2*WIDTH:WIDTH+1];
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          bad = bad + 1;
        end else begin
          want = expected_q.pop_front();
          if (got.inverse !== want.inverse) begin
            $display("%0t: inverse expected %h actual %h", $time, want.inverse, got.inverse);
            bad = bad + 1;
          end
          if (got.exists !== want.exists) begin
            $display("%0t: exists expected %b actual %b", $time, want.exists, got.exists);
            bad = bad + 1;
          end
          if (got.divisor !== want.divisor) begin
            $display("%0t: gcd expected %h actual %h", $time, want.divisor, got.divisor);
            bad = bad + 1;
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_q = {expected_q,
                      solve_inverse(s_tdata[WIDTH-1:0], s_tdata[2*WIDTH-1:WIDTH])};
      errors <= errors + bad;
      pending <= expected_q.size();
    end
  end
endmodule

// ===== test/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W = 32;
  localparam int Limit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [2*W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [2*W+7:0] m_tdata;
  int errors, pending;
  int sender_idle = 0, receiver_idle = 0;
  int quiet = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  modular_inverse #(.WIDTH(W)) DUT (.*);

  modinv_checker #(.WIDTH(W)) checker_i (.*);

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= receiver_idle);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= Limit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send(logic [W-1:0] a, logic [W-1:0] m);
    while ($urandom_range(99) < sender_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {m, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [W-1:0] rand_word();
    case ($urandom_range(3))
      0: return $urandom_range(20);
      1: return $urandom_range(1000);
      2: return {$urandom} >> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  logic [W-1:0] p, k;

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send(0, 0);
    send('1, 0);
    send(5, 1);
    send(0, 7);
    send(0, 1);
    send(3, 7);
    send(10, 7);
    send(6, 9);
    send(2, 1024);
    send('1, '1);
    send('1 - 1, '1);
    send(1, '1);
    send(32'hFFFF_FFFB, 32'hFFFF_FFFA);
    send(32'h8000_0000, 32'hFFFF_FFFF);
    send(32'hB504_F333, 32'hFFFF_FFFB);
    send(32'h9E37_79B9, 32'hB504_F333);
    send(1, 2);
    send(7, 1000);
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle   = (phase == 0) ? 13 : (phase == 1) ? 66 : 0;
      receiver_idle = (phase == 0) ? 66 : (phase == 1) ? 13 : 0;
      for (int i = 0; i < 130; i++) begin
        p = rand_word();
        k = rand_word();
        if ($urandom_range(4) == 0) p = k * $urandom_range(5) + $urandom_range(1);
        send(p, k);
      end
      s_tvalid <= 1'b0;
      @(posedge clk);
      while (pending != 0) @(posedge clk);
    end
    repeat (50) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
